>>> rtl/qmm_pkg.sv
package qmm_pkg;

   localparam int MOTOR_COUNT     = 4;
   localparam int NUM_AXES        = 4;
   localparam int COEFF_WIDTH_DEF = 16;
   localparam int NUM_REGS        = 8;
   localparam int REG_IDX_W       = $clog2(NUM_REGS);
   localparam int CSR_IDX_W       = 4;
   localparam int MIDX_W          = $clog2(MOTOR_COUNT);

   // register indexes
   localparam int REG_FWD   = 4;
   localparam int REG_RIGHT = 5;
   localparam int REG_YAW   = 6;
   localparam int REG_GAIN  = 7;

   localparam int ONE_Q14 = 16384;
   localparam int ACC_ONE = 1 << 27;
   localparam int TERM_W  = 27;

   typedef enum logic [1:0] {
      ST_OK     = 2'd0,
      ST_BOUNDS = 2'd1,
      ST_DESAT  = 2'd2
   } status_type;

   typedef struct packed {
      logic [14:0]              cmd;
      logic [15:0]              speed;
      logic [23:0]              thrust;
      logic signed [TERM_W-1:0] roll;
      logic signed [TERM_W-1:0] pitch;
      logic signed [TERM_W-1:0] yaw;
   } lane_res_type;

endpackage

>>> rtl/quad_motor_mixer_thrust_model.sv
// Channel   Direction  Handshake            Word
// req_      in         req_valid/req_stall  roll, pitch, yaw torque, collective command
// rsp_      out        rsp_valid/rsp_stall  status, motor, setpoint, speed, thrust, sums, last
// csr_      in         csr_valid/csr_ready  register index, 64-bit write data
//
// An item yields one result word per motor, or a single word when it is rejected;
// the merge stage emits one word per cycle while rsp_ is not stalled. The first word
// reaches rsp_ through ten lane stages, the merge buffer and the output register.
// Reset is synchronous and clears the valid bits and the configuration registers;
// datapath registers are left as they are, no clearing pass.
// While the merge buffer holds an item that cannot leave this cycle (words still to
// go, or a stall on rsp_), every lane stage holds and req_stall is high.
module quad_motor_mixer_thrust_model import qmm_pkg::*; #(
   parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic signed [15:0]   req_roll_torque,
   input  logic signed [15:0]   req_pitch_torque,
   input  logic signed [15:0]   req_yaw_torque,
   input  logic [14:0]          req_collective_command,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [1:0]           rsp_status,
   output logic [1:0]           rsp_motor_index,
   output logic [14:0]          rsp_motor_setpoint,
   output logic [15:0]          rsp_rotor_speed,
   output logic [23:0]          rsp_rotor_thrust,
   output logic [25:0]          rsp_collective_thrust,
   output logic signed [31:0]   rsp_moment_roll,
   output logic signed [31:0]   rsp_moment_pitch,
   output logic signed [31:0]   rsp_moment_yaw,
   output logic                 rsp_last,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata
);

   // lane stages 0..9: input, products, sum, command, speed, square, gain,
   // thrust, moment products, moment terms
   localparam int DEPTH    = 10;
   localparam int ST_DEPTH = 7;

   logic [63:0]          csr_ff [NUM_REGS];
   logic                 advance;
   logic [DEPTH-1:0]     vld_ff;
   logic signed [15:0]   ctl_ff [NUM_AXES];
   logic                 werr_in, werr0_ff, werr1_ff, werr2_ff;
   logic [MOTOR_COUNT-1:0] lane_fail;
   lane_res_type         lane_res [MOTOR_COUNT];
   status_type           st_in;
   logic [MIDX_W-1:0]    mot_in;
   status_type           st_ff  [ST_DEPTH];
   logic [MIDX_W-1:0]    mot_ff [ST_DEPTH];

   // registers take writes at any time; index beyond the list is dropped
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < NUM_REGS; r++) begin
            csr_ff[r] <= '0;
         end
      end else if (csr_valid && (csr_index < CSR_IDX_W'(NUM_REGS))) begin
         csr_ff[csr_index[REG_IDX_W-1:0]] <= csr_wdata;
      end
   end

   // whole pipeline moves as one whenever the merge buffer can take a word
   assign req_stall = !advance;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (advance) begin
         vld_ff <= {vld_ff[DEPTH-2:0], req_valid};
      end
   end

   // wrench bounds: any torque beyond plus or minus one, collective above one
   assign werr_in = (req_roll_torque  > ONE_Q14) || (req_roll_torque  < -ONE_Q14) ||
                    (req_pitch_torque > ONE_Q14) || (req_pitch_torque < -ONE_Q14) ||
                    (req_yaw_torque   > ONE_Q14) || (req_yaw_torque   < -ONE_Q14) ||
                    (req_collective_command > 15'(ONE_Q14));

   always_ff @(posedge clock) begin
      if (advance) begin
         ctl_ff[0] <= req_roll_torque;
         ctl_ff[1] <= req_pitch_torque;
         ctl_ff[2] <= req_yaw_torque;
         ctl_ff[3] <= -$signed({1'b0, req_collective_command});
         werr0_ff  <= werr_in;
         werr1_ff  <= werr0_ff;
         werr2_ff  <= werr1_ff;
      end
   end

   // status settles at stage 3: bounds first, then the lowest failing motor
   always_comb begin
      st_in  = ST_OK;
      mot_in = '0;
      if (werr2_ff) begin
         st_in = ST_BOUNDS;
      end else if (|lane_fail) begin
         st_in = ST_DESAT;
         for (int m = MOTOR_COUNT - 1; m >= 0; m--) begin
            if (lane_fail[m]) begin
               mot_in = MIDX_W'(m);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         st_ff[0]  <= st_in;
         mot_ff[0] <= mot_in;
         for (int k = 1; k < ST_DEPTH; k++) begin
            st_ff[k]  <= st_ff[k-1];
            mot_ff[k] <= mot_ff[k-1];
         end
      end
   end

   for (genvar m = 0; m < MOTOR_COUNT; m++) begin : g_lane
      qmm_lane #(
         .COEFF_WIDTH (COEFF_WIDTH)
      ) u_lane (
         .clock        (clock),
         .advance      (advance),
         .mix_row      (csr_ff[m]),
         .ctl          (ctl_ff),
         .speed_min    (csr_ff[REG_GAIN][15:0]),
         .speed_span   (csr_ff[REG_GAIN][31:16]),
         .thrust_gain  (csr_ff[REG_GAIN][63:32]),
         .fwd_offset   ($signed(csr_ff[REG_FWD][16*m +: 16])),
         .right_offset ($signed(csr_ff[REG_RIGHT][16*m +: 16])),
         .yaw_ratio    ($signed(csr_ff[REG_YAW][16*m +: 16])),
         .fail         (lane_fail[m]),
         .res          (lane_res[m])
      );
   end

   qmm_merge u_merge (
      .clock                 (clock),
      .reset                 (reset),
      .in_valid              (vld_ff[DEPTH-1]),
      .in_status             (st_ff[ST_DEPTH-1]),
      .in_motor              (mot_ff[ST_DEPTH-1]),
      .in_res                (lane_res),
      .advance               (advance),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_motor_index       (rsp_motor_index),
      .rsp_motor_setpoint    (rsp_motor_setpoint),
      .rsp_rotor_speed       (rsp_rotor_speed),
      .rsp_rotor_thrust      (rsp_rotor_thrust),
      .rsp_collective_thrust (rsp_collective_thrust),
      .rsp_moment_roll       (rsp_moment_roll),
      .rsp_moment_pitch      (rsp_moment_pitch),
      .rsp_moment_yaw        (rsp_moment_yaw),
      .rsp_last              (rsp_last)
   );

endmodule

>>> rtl/qmm_lane.sv
module qmm_lane import qmm_pkg::*; #(
   parameter int COEFF_WIDTH = COEFF_WIDTH_DEF
) (
   input  logic               clock,
   input  logic               advance,
   input  logic [63:0]        mix_row,
   input  logic signed [15:0] ctl [NUM_AXES],
   input  logic [15:0]        speed_min,
   input  logic [15:0]        speed_span,
   input  logic [31:0]        thrust_gain,
   input  logic signed [15:0] fwd_offset,
   input  logic signed [15:0] right_offset,
   input  logic signed [15:0] yaw_ratio,
   output logic               fail,
   output lane_res_type       res
);

   localparam int PROD_W = COEFF_WIDTH + 16;
   localparam int ACC_W  = PROD_W + 2;
   localparam int MP_W   = 41;

   logic signed [COEFF_WIDTH-1:0] coef [NUM_AXES];
   logic signed [PROD_W-1:0]      prod_in [NUM_AXES];
   logic signed [PROD_W-1:0]      prod_ff [NUM_AXES];
   logic signed [ACC_W-1:0]       acc_in, acc_ff, acc_rnd;
   logic                          fail_in, fail_ff;
   logic [14:0]                   cmd3_in;
   logic [14:0]                   cmd3_ff, cmd4_ff, cmd5_ff, cmd6_ff, cmd7_ff, cmd8_ff;
   logic [30:0]                   sprod_in, sprod_ff;
   logic [17:0]                   sp_sum;
   logic [15:0]                   speed_in, speed4_ff, speed5_ff, speed6_ff, speed7_ff;
   logic [15:0]                   speed8_ff;
   logic [31:0]                   sq_in, sq_ff;
   logic [63:0]                   kp_in, kp_ff, kp_rnd;
   logic [23:0]                   thrust_in, thrust7_ff, thrust8_ff;
   logic signed [24:0]            th_s;
   logic signed [MP_W-1:0]        mr_in, mp_in, my_in, mr_ff, mp_ff, my_ff;
   logic signed [MP_W-1:0]        rr, rp, ry;
   lane_res_type                  res_in, res_ff;

   // mixer products, one per axis
   always_comb begin
      for (int a = 0; a < NUM_AXES; a++) begin
         coef[a]    = $signed(mix_row[16*a +: COEFF_WIDTH]);
         prod_in[a] = coef[a] * ctl[a];
      end
   end

   always_comb begin
      acc_in = '0;
      for (int a = 0; a < NUM_AXES; a++) begin
         acc_in = acc_in + ACC_W'(prod_ff[a]);
      end
      fail_in = (acc_in < 0) || (acc_in > $signed(ACC_W'(ACC_ONE)));
   end

   // round to Q1.14 and scale onto the speed span
   always_comb begin
      acc_rnd  = acc_ff + ACC_W'(4096);
      cmd3_in  = acc_rnd[27:13];
      sprod_in = 31'(speed_span) * 31'(cmd3_in);
   end

   always_comb begin
      sp_sum   = 18'(speed_min) + 18'((32'(sprod_ff) + 32'd8192) >> 14);
      speed_in = (sp_sum > 18'd65535) ? 16'hFFFF : sp_sum[15:0];
      sq_in    = 32'(speed4_ff) * 32'(speed4_ff);
      kp_in    = 64'(thrust_gain) * 64'(sq_ff);
   end

   always_comb begin
      kp_rnd    = kp_ff + 64'h0000_0000_0080_0000;
      thrust_in = (|kp_rnd[63:48]) ? 24'hFF_FFFF : kp_rnd[47:24];
      th_s      = $signed({1'b0, thrust7_ff});
      mr_in     = right_offset * th_s;
      mp_in     = fwd_offset * th_s;
      my_in     = yaw_ratio * th_s;
   end

   // floor after the half-up offset
   always_comb begin
      rr = MP_W'(8192) - mr_ff;
      rp = mp_ff + MP_W'(8192);
      ry = my_ff + MP_W'(16384);
      res_in.cmd    = cmd8_ff;
      res_in.speed  = speed8_ff;
      res_in.thrust = thrust8_ff;
      res_in.roll   = TERM_W'(rr >>> 14);
      res_in.pitch  = TERM_W'(rp >>> 14);
      res_in.yaw    = TERM_W'(ry >>> 15);
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         for (int a = 0; a < NUM_AXES; a++) begin
            prod_ff[a] <= prod_in[a];
         end
         acc_ff     <= acc_in;
         fail_ff    <= fail_in;
         cmd3_ff    <= cmd3_in;
         sprod_ff   <= sprod_in;
         cmd4_ff    <= cmd3_ff;
         speed4_ff  <= speed_in;
         cmd5_ff    <= cmd4_ff;
         speed5_ff  <= speed4_ff;
         sq_ff      <= sq_in;
         cmd6_ff    <= cmd5_ff;
         speed6_ff  <= speed5_ff;
         kp_ff      <= kp_in;
         cmd7_ff    <= cmd6_ff;
         speed7_ff  <= speed6_ff;
         thrust7_ff <= thrust_in;
         cmd8_ff    <= cmd7_ff;
         speed8_ff  <= speed7_ff;
         thrust8_ff <= thrust7_ff;
         mr_ff      <= mr_in;
         mp_ff      <= mp_in;
         my_ff      <= my_in;
         res_ff     <= res_in;
      end
   end

   assign fail = fail_ff;
   assign res  = res_ff;

endmodule

>>> rtl/qmm_merge.sv
module qmm_merge import qmm_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_valid,
   input  status_type         in_status,
   input  logic [MIDX_W-1:0]  in_motor,
   input  lane_res_type       in_res [MOTOR_COUNT],
   output logic               advance,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [1:0]         rsp_status,
   output logic [1:0]         rsp_motor_index,
   output logic [14:0]        rsp_motor_setpoint,
   output logic [15:0]        rsp_rotor_speed,
   output logic [23:0]        rsp_rotor_thrust,
   output logic [25:0]        rsp_collective_thrust,
   output logic signed [31:0] rsp_moment_roll,
   output logic signed [31:0] rsp_moment_pitch,
   output logic signed [31:0] rsp_moment_yaw,
   output logic               rsp_last
);

   function automatic logic signed [31:0] sat_add(input logic signed [31:0] a,
                                                  input logic signed [TERM_W-1:0] b);
      logic signed [32:0] s;
      s = 33'(a) + 33'(b);
      if (s[32] != s[31]) begin
         return s[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
      end
      return s[31:0];
   endfunction

   logic                buf_valid_ff;
   status_type          buf_status_ff;
   logic [MIDX_W-1:0]   buf_motor_ff;
   lane_res_type        buf_res_ff [MOTOR_COUNT];
   logic [MIDX_W-1:0]   idx_ff;
   logic                rsp_valid_ff;
   logic                out_load, word_last, first;
   lane_res_type        cur;
   logic [25:0]         csum_ff, csum_in;
   logic [26:0]         csum_sum;
   logic signed [31:0]  roll_ff, pitch_ff, yaw_ff, roll_in, pitch_in, yaw_in;

   assign out_load  = buf_valid_ff && (!rsp_valid_ff || !rsp_stall);
   assign word_last = (buf_status_ff != ST_OK) || (idx_ff == MIDX_W'(MOTOR_COUNT - 1));
   assign advance   = !buf_valid_ff || (out_load && word_last);
   assign cur       = buf_res_ff[idx_ff];
   assign first     = (idx_ff == '0);

   // running sums restart on the first motor of each item
   always_comb begin
      csum_sum = 27'(first ? 26'd0 : csum_ff) + 27'(cur.thrust);
      csum_in  = csum_sum[26] ? 26'h3FF_FFFF : csum_sum[25:0];
      roll_in  = sat_add(first ? 32'sd0 : roll_ff, cur.roll);
      pitch_in = sat_add(first ? 32'sd0 : pitch_ff, cur.pitch);
      yaw_in   = sat_add(first ? 32'sd0 : yaw_ff, cur.yaw);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         buf_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         idx_ff       <= '0;
      end else begin
         if (advance) begin
            buf_valid_ff <= in_valid;
         end
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
            if (buf_status_ff == ST_OK) begin
               idx_ff <= word_last ? '0 : idx_ff + 1'b1;
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance && in_valid) begin
         buf_status_ff <= in_status;
         buf_motor_ff  <= in_motor;
         for (int m = 0; m < MOTOR_COUNT; m++) begin
            buf_res_ff[m] <= in_res[m];
         end
      end
      if (out_load) begin
         rsp_status <= buf_status_ff;
         rsp_last   <= word_last;
         if (buf_status_ff == ST_OK) begin
            csum_ff               <= csum_in;
            roll_ff               <= roll_in;
            pitch_ff              <= pitch_in;
            yaw_ff                <= yaw_in;
            rsp_motor_index       <= 2'(idx_ff);
            rsp_motor_setpoint    <= cur.cmd;
            rsp_rotor_speed       <= cur.speed;
            rsp_rotor_thrust      <= cur.thrust;
            rsp_collective_thrust <= csum_in;
            rsp_moment_roll       <= roll_in;
            rsp_moment_pitch      <= pitch_in;
            rsp_moment_yaw        <= yaw_in;
         end else begin
            rsp_motor_index       <= 2'(buf_motor_ff);
            rsp_motor_setpoint    <= '0;
            rsp_rotor_speed       <= '0;
            rsp_rotor_thrust      <= '0;
            rsp_collective_thrust <= '0;
            rsp_moment_roll       <= '0;
            rsp_moment_pitch      <= '0;
            rsp_moment_yaw        <= '0;
         end
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

>>> verif/qmm_allocation_checker.sv
`timescale 1ns / 1ps

module qmm_allocation_checker import qmm_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_stall,
   input  logic signed [15:0]   req_roll_torque,
   input  logic signed [15:0]   req_pitch_torque,
   input  logic signed [15:0]   req_yaw_torque,
   input  logic [14:0]          req_collective_command,
   input  logic                 rsp_valid,
   input  logic                 rsp_stall,
   input  logic [1:0]           rsp_status,
   input  logic [1:0]           rsp_motor_index,
   input  logic [14:0]          rsp_motor_setpoint,
   input  logic [15:0]          rsp_rotor_speed,
   input  logic [23:0]          rsp_rotor_thrust,
   input  logic [25:0]          rsp_collective_thrust,
   input  logic signed [31:0]   rsp_moment_roll,
   input  logic signed [31:0]   rsp_moment_pitch,
   input  logic signed [31:0]   rsp_moment_yaw,
   input  logic                 rsp_last,
   input  logic                 csr_valid,
   input  logic                 csr_ready,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [63:0]          csr_wdata,
   output int                   mismatch_count,
   output int                   words_pending
);

   typedef struct packed {
      status_type  status;
      logic [1:0]  motor;
      logic [14:0] cmd;
      logic [15:0] speed;
      logic [23:0] thrust;
      logic [25:0] csum;
      logic [31:0] roll_mom;
      logic [31:0] pitch_mom;
      logic [31:0] yaw_mom;
      logic        last;
   } motor_word_type;

   logic [63:0]    mix_regs [NUM_REGS];
   motor_word_type motor_words_due [$];
   motor_word_type seen_word;
   motor_word_type due_word;
   int             bad_count = 0;
   int             words_seen = 0;

   assign mismatch_count = bad_count;
   assign words_pending  = motor_words_due.size();

   function automatic longint lane_of(logic [63:0] r, int lane);
      return longint'($signed(r[16*lane +: 16]));
   endfunction

   // round half up towards plus infinity: an arithmetic shift of the biased value
   function automatic longint round_q(longint v, int s);
      return (v + (longint'(1) <<< (s - 1))) >>> s;
   endfunction

   function automatic longint sat_moment(longint v);
      if (v > longint'(32'sh7FFF_FFFF)) return longint'(32'sh7FFF_FFFF);
      if (v < longint'(32'sh8000_0000)) return longint'(32'sh8000_0000);
      return v;
   endfunction

   task automatic forecast_words(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                                 input logic signed [15:0] yaw, input logic [14:0] coll);
      longint         ctl [4];
      longint         cmd [MOTOR_COUNT];
      longint         acc;
      longint         mr;
      longint         mp;
      longint         my;
      longint         t;
      logic [63:0]    speed;
      logic [63:0]    thrust;
      logic [63:0]    csum;
      logic [63:0]    smin;
      logic [63:0]    span;
      logic [63:0]    kth;
      int             fail_motor;
      motor_word_type w;

      ctl[0] = roll;
      ctl[1] = pitch;
      ctl[2] = yaw;
      ctl[3] = -longint'(coll);
      smin   = mix_regs[REG_GAIN][15:0];
      span   = mix_regs[REG_GAIN][31:16];
      kth    = mix_regs[REG_GAIN][63:32];
      w      = '0;

      for (int a = 0; a < 3; a++) begin
         if (ctl[a] > ONE_Q14 || ctl[a] < -ONE_Q14) w.status = ST_BOUNDS;
      end
      if (coll > ONE_Q14) w.status = ST_BOUNDS;
      if (w.status == ST_BOUNDS) begin
         w.last = 1'b1;
         motor_words_due.push_back(w);
         return;
      end

      fail_motor = -1;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         if (fail_motor < 0) begin
            acc = 0;
            for (int a = 0; a < NUM_AXES; a++) acc += lane_of(mix_regs[m], a) * ctl[a];
            if (acc < 0 || acc > ACC_ONE) fail_motor = m;
            else cmd[m] = (acc + 4096) >>> 13;
         end
      end
      if (fail_motor >= 0) begin
         w.status = ST_DESAT;
         w.motor  = 2'(fail_motor);
         w.last   = 1'b1;
         motor_words_due.push_back(w);
         return;
      end

      csum = '0;
      mr   = 0;
      mp   = 0;
      my   = 0;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         speed = smin + ((span * 64'(cmd[m]) + 64'd8192) >> 14);
         if (speed > 64'd65535) speed = 64'd65535;
         thrust = (kth * (speed * speed) + (64'd1 << 23)) >> 24;
         if (thrust > 64'hFF_FFFF) thrust = 64'hFF_FFFF;
         csum += thrust;
         if (csum > 64'h3FF_FFFF) csum = 64'h3FF_FFFF;
         t  = longint'(thrust);
         mr = sat_moment(mr + round_q(-lane_of(mix_regs[REG_RIGHT], m) * t, 14));
         mp = sat_moment(mp + round_q(lane_of(mix_regs[REG_FWD], m) * t, 14));
         my = sat_moment(my + round_q(lane_of(mix_regs[REG_YAW], m) * t, 15));

         w.status    = ST_OK;
         w.motor     = 2'(m);
         w.cmd       = 15'(cmd[m]);
         w.speed     = 16'(speed);
         w.thrust    = 24'(thrust);
         w.csum      = 26'(csum);
         w.roll_mom  = 32'(mr);
         w.pitch_mom = 32'(mp);
         w.yaw_mom   = 32'(my);
         w.last      = (m == MOTOR_COUNT - 1);
         motor_words_due.push_back(w);
      end
   endtask

   task automatic check_field(input string name, input logic [31:0] e, input logic [31:0] g);
      if (e !== g) begin
         if (bad_count < 10)
            $display("%0t: word %0d field %s expected %0h got %0h", $realtime, words_seen,
                     name, e, g);
         bad_count++;
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_REGS; i++) mix_regs[i] = '0;
         motor_words_due.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            seen_word = '{status_type'(rsp_status), rsp_motor_index, rsp_motor_setpoint,
                          rsp_rotor_speed, rsp_rotor_thrust, rsp_collective_thrust,
                          rsp_moment_roll, rsp_moment_pitch, rsp_moment_yaw, rsp_last};
            if (motor_words_due.size() == 0) begin
               if (bad_count < 10)
                  $display("%0t: word %0d arrived with none outstanding", $realtime,
                           words_seen);
               bad_count++;
            end else begin
               due_word = motor_words_due.pop_front();
               check_field("status", 32'(due_word.status), 32'(seen_word.status));
               check_field("motor_index", 32'(due_word.motor), 32'(seen_word.motor));
               check_field("motor_setpoint", 32'(due_word.cmd), 32'(seen_word.cmd));
               check_field("rotor_speed", 32'(due_word.speed), 32'(seen_word.speed));
               check_field("rotor_thrust", 32'(due_word.thrust), 32'(seen_word.thrust));
               check_field("collective_thrust", 32'(due_word.csum), 32'(seen_word.csum));
               check_field("moment_roll", due_word.roll_mom, seen_word.roll_mom);
               check_field("moment_pitch", due_word.pitch_mom, seen_word.pitch_mom);
               check_field("moment_yaw", due_word.yaw_mom, seen_word.yaw_mom);
               check_field("last", 32'(due_word.last), 32'(seen_word.last));
            end
            words_seen++;
         end
         if (req_valid && !req_stall)
            forecast_words(req_roll_torque, req_pitch_torque, req_yaw_torque,
                           req_collective_command);
         // indexes past the register file are dropped by the block
         if (csr_valid && csr_ready && csr_index < NUM_REGS)
            mix_regs[csr_index[REG_IDX_W-1:0]] = csr_wdata;
      end
   end

endmodule

>>> verif/tb_quad_motor_mixer_thrust_model.sv
`timescale 1ns / 1ps

module tb_quad_motor_mixer_thrust_model;
   import qmm_pkg::*;

   // stimulus side: everything driven here changes on the falling edge only
   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic signed [15:0]   req_roll_torque = '0;
   logic signed [15:0]   req_pitch_torque = '0;
   logic signed [15:0]   req_yaw_torque = '0;
   logic [14:0]          req_collective_command = '0;
   logic                 rsp_stall = 1'b0;
   logic                 csr_valid = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [63:0]          csr_wdata = '0;

   // block outputs
   logic                 req_stall;
   logic                 rsp_valid;
   logic [1:0]           rsp_status;
   logic [1:0]           rsp_motor_index;
   logic [14:0]          rsp_motor_setpoint;
   logic [15:0]          rsp_rotor_speed;
   logic [23:0]          rsp_rotor_thrust;
   logic [25:0]          rsp_collective_thrust;
   logic signed [31:0]   rsp_moment_roll;
   logic signed [31:0]   rsp_moment_pitch;
   logic signed [31:0]   rsp_moment_yaw;
   logic                 rsp_last;
   logic                 csr_ready;

   int mismatches;
   int pending;

   // X layout: sign of each torque axis in every motor's mixer row
   int roll_sign  [MOTOR_COUNT] = '{-1, 1, 1, -1};
   int pitch_sign [MOTOR_COUNT] = '{1, -1, 1, -1};
   int yaw_sign   [MOTOR_COUNT] = '{1, 1, -1, -1};
   int bound_vals [6] = '{16384, 16385, -16384, -16385, 32767, -32768};

   // set while the sender runs words back to back with no gaps
   bit back_to_back = 1'b0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   quad_motor_mixer_thrust_model DUT (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_roll_torque       (req_roll_torque),
      .req_pitch_torque      (req_pitch_torque),
      .req_yaw_torque        (req_yaw_torque),
      .req_collective_command(req_collective_command),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_motor_index       (rsp_motor_index),
      .rsp_motor_setpoint    (rsp_motor_setpoint),
      .rsp_rotor_speed       (rsp_rotor_speed),
      .rsp_rotor_thrust      (rsp_rotor_thrust),
      .rsp_collective_thrust (rsp_collective_thrust),
      .rsp_moment_roll       (rsp_moment_roll),
      .rsp_moment_pitch      (rsp_moment_pitch),
      .rsp_moment_yaw        (rsp_moment_yaw),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata)
   );

   qmm_allocation_checker u_checker (
      .clock                 (clock),
      .reset                 (reset),
      .req_valid             (req_valid),
      .req_stall             (req_stall),
      .req_roll_torque       (req_roll_torque),
      .req_pitch_torque      (req_pitch_torque),
      .req_yaw_torque        (req_yaw_torque),
      .req_collective_command(req_collective_command),
      .rsp_valid             (rsp_valid),
      .rsp_stall             (rsp_stall),
      .rsp_status            (rsp_status),
      .rsp_motor_index       (rsp_motor_index),
      .rsp_motor_setpoint    (rsp_motor_setpoint),
      .rsp_rotor_speed       (rsp_rotor_speed),
      .rsp_rotor_thrust      (rsp_rotor_thrust),
      .rsp_collective_thrust (rsp_collective_thrust),
      .rsp_moment_roll       (rsp_moment_roll),
      .rsp_moment_pitch      (rsp_moment_pitch),
      .rsp_moment_yaw        (rsp_moment_yaw),
      .rsp_last              (rsp_last),
      .csr_valid             (csr_valid),
      .csr_ready             (csr_ready),
      .csr_index             (csr_index),
      .csr_wdata             (csr_wdata),
      .mismatch_count        (mismatches),
      .words_pending         (pending)
   );

   // Idle length for either side: mostly none or short, now and then long.
   function automatic int pick_pause();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 40);
   endfunction

   // Receiver: alternate free runs (sometimes long, so stretches see no stall
   // at all) with stalls of random length.
   initial begin : rsp_backpressure
      int run;
      forever begin
         run = $urandom_range(1, ($urandom_range(0, 9) == 0) ? 120 : 12);
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b0;
         end
         run = pick_pause();
         repeat (run) begin
            @(negedge clock);
            rsp_stall <= 1'b1;
         end
      end
   end

   // Write one register and wait for the handshake; drop valid on the next fall.
   task automatic write_reg(input int idx, input logic [63:0] data);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_index <= CSR_IDX_W'(idx);
      csr_wdata <= data;
      do @(posedge clock); while (!csr_ready);
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Offer one wrench word after a random gap and hold it until accepted.
   // With no gap valid simply stays high into the next word.
   task automatic send_wrench(input logic signed [15:0] roll, input logic signed [15:0] pitch,
                              input logic signed [15:0] yaw, input logic [14:0] coll);
      int gap;
      gap = back_to_back ? 0 : pick_pause();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
      @(negedge clock);
      req_valid              <= 1'b1;
      req_roll_torque        <= roll;
      req_pitch_torque       <= pitch;
      req_yaw_torque         <= yaw;
      req_collective_command <= coll;
      do @(posedge clock); while (req_stall);
   endtask

   // Hold the sender off until every outstanding word is back, then let the
   // lane stages empty before anything touches the registers.
   task automatic drain_words();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (16) @(negedge clock);
   endtask

   // Load the four mixer rows: X layout of given magnitude, random jitter per
   // lane, and a negative thrust coefficient drawn from thr_lo..thr_hi.
   task automatic load_mixer(input int mag, input int jitter, input int thr_lo,
                             input int thr_hi);
      int r;
      int p;
      int y;
      int thr;
      for (int m = 0; m < MOTOR_COUNT; m++) begin
         r   = roll_sign[m] * mag + int'($urandom_range(0, 2 * jitter)) - jitter;
         p   = pitch_sign[m] * mag + int'($urandom_range(0, 2 * jitter)) - jitter;
         y   = yaw_sign[m] * mag + int'($urandom_range(0, 2 * jitter)) - jitter;
         thr = -int'($urandom_range(thr_lo, thr_hi));
         write_reg(m, {16'(thr), 16'(y), 16'(p), 16'(r)});
      end
   endtask

   // Random wrenches: mostly well-formed hover-like words, the rest full-range
   // noise and words sitting on the bounds.
   task automatic send_random_wrenches(input int n);
      int                 pick;
      int                 span_t;
      logic signed [15:0] t [3];
      logic [14:0]        c;
      for (int i = 0; i < n; i++) begin
         if (i % 32 == 0) back_to_back = ($urandom_range(0, 3) == 0);
         pick = $urandom_range(0, 99);
         if (pick < 80) begin
            span_t = ($urandom_range(0, 4) == 0) ? 5000 : 2200;
            for (int a = 0; a < 3; a++)
               t[a] = 16'(int'($urandom_range(0, 2 * span_t)) - span_t);
            c = 15'($urandom_range(5000, 11000));
         end else if (pick < 90) begin
            for (int a = 0; a < 3; a++) t[a] = 16'($urandom);
            c = 15'($urandom);
         end else begin
            for (int a = 0; a < 3; a++) t[a] = '0;
            t[$urandom_range(0, 2)] = 16'(bound_vals[$urandom_range(0, 5)]);
            c = 15'($urandom_range(16380, 16388));
         end
         send_wrench(t[0], t[1], t[2], c);
      end
      back_to_back = 1'b0;
   endtask

   initial begin : stimulus
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // registers at reset: every coefficient zero, so commands sit at zero
      send_wrench(16'sd0, 16'sd0, 16'sd0, 15'd0);
      send_wrench(16'sd0, 16'sd0, 16'sd0, 15'd16384);
      send_wrench(16'sd16385, 16'sd0, 16'sd0, 15'd0);
      send_wrench(16'sd0, 16'sd0, 16'sd0, 15'd16385);
      drain_words();

      // writes past the register file must leave everything untouched
      write_reg(NUM_REGS, '1);
      write_reg((1 << CSR_IDX_W) - 1, '1);
      send_wrench(16'sd0, 16'sd0, 16'sd0, 15'd8192);
      drain_words();

      // nominal airframe: half-gain X mixer, thrust coefficient of -1.0
      load_mixer(4096, 0, 8192, 8192);
      write_reg(REG_FWD, {16'sd1638, -16'sd1638, 16'sd1638, -16'sd1638});
      write_reg(REG_RIGHT, {-16'sd1638, 16'sd1638, 16'sd1638, -16'sd1638});
      write_reg(REG_YAW, {-16'sd524, -16'sd524, 16'sd524, 16'sd524});
      write_reg(REG_GAIN, {32'd42950, 16'd14400, 16'd1600});

      send_wrench(16'sd0, 16'sd0, 16'sd0, 15'd8192);
      // odd roll: command lands exactly on a half and rounds up
      send_wrench(16'sd1, 16'sd0, 16'sd0, 15'd8192);
      send_wrench(-16'sd1, 16'sd0, 16'sd0, 15'd8192);
      // full torque on one axis puts commands exactly on 0 and 1.0
      send_wrench(16'sd16384, 16'sd0, 16'sd0, 15'd8192);
      send_wrench(-16'sd16384, 16'sd0, 16'sd0, 15'd8192);
      send_wrench(16'sd0, 16'sd16384, 16'sd0, 15'd8192);
      send_wrench(16'sd0, 16'sd0, -16'sd16384, 15'd8192);
      // wrench out of bounds, each axis and the collective
      send_wrench(-16'sd16385, 16'sd0, 16'sd0, 15'd8192);
      send_wrench(16'sd0, -16'sd16385, 16'sd0, 15'd8192);
      send_wrench(16'sd0, 16'sd16385, 16'sd0, 15'd8192);
      send_wrench(16'sd0, 16'sd0, 16'sd16385, 15'd8192);
      send_wrench(-16'sd32768, 16'sd32767, -16'sd32768, 15'd32767);
      send_wrench(16'sd0, 16'sd0, 16'sd0, 15'd32767);
      // desaturation: push each motor alone above 1.0, then one below zero
      for (int m = 0; m < MOTOR_COUNT; m++)
         send_wrench(16'(roll_sign[m] * 8000), 16'(pitch_sign[m] * 8000),
                     16'(yaw_sign[m] * 8000), 15'd8192);
      send_wrench(16'sd2, 16'sd0, 16'sd0, 15'd0);

      send_random_wrenches(150);
      drain_words();

      // most negative coefficients: collective 4096 gives exactly 1.0, 4097 is over
      for (int m = 0; m < MOTOR_COUNT; m++) write_reg(m, 64'h8000_8000_8000_8000);
      write_reg(REG_FWD, 64'h8000_8000_8000_8000);
      write_reg(REG_RIGHT, 64'h7FFF_7FFF_7FFF_7FFF);
      write_reg(REG_YAW, 64'h8000_8000_8000_8000);
      write_reg(REG_GAIN, '1);
      send_wrench(16'sd0, 16'sd0, 16'sd0, 15'd4096);
      send_wrench(16'sd0, 16'sd0, 16'sd0, 15'd4097);
      drain_words();

      // all-ones rows: tiny commands, but speed and thrust pinned at saturation
      for (int m = 0; m < MOTOR_COUNT; m++) write_reg(m, '1);
      send_random_wrenches(30);
      drain_words();

      // random airframes: jittered mixers, arbitrary geometry and gains
      repeat (3) begin
         load_mixer($urandom_range(1000, 6000), 300, 6000, 9000);
         write_reg(REG_FWD, {$urandom, $urandom});
         write_reg(REG_RIGHT, {$urandom, $urandom});
         write_reg(REG_YAW, {$urandom, $urandom});
         write_reg(REG_GAIN, {32'($urandom >> $urandom_range(0, 24)),
                              16'($urandom_range(0, 65535)), 16'($urandom_range(0, 8000))});
         send_random_wrenches(50);
         drain_words();
      end

      repeat (40) @(negedge clock);
      if (mismatches == 0 && pending == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

   // watchdog: several times the slowest legal run
   initial begin : watchdog
      #5000000;
      $display("RESULT: ERROR");
      $finish;
   end

endmodule
